// File: design/led_drv_pkg.sv
// Shared types, register indexes and reset values for the single-pixel LED strip driver.
// Used by every module of the design; depends on nothing.
package led_drv_pkg;

  localparam int CNT_W       = 16;
  localparam int LEN_W       = 8;
  localparam int COLOR_BITS  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8;

  localparam int DEF_BITS_PER_LED   = 24;
  localparam int DEF_MAX_STRIP_LEDS = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEN  = 3'd4;

  localparam logic [CNT_W-1:0] RST_ONE_HIGH   = 16'd51;
  localparam logic [CNT_W-1:0] RST_ZERO_HIGH  = 16'd26;
  localparam logic [CNT_W-1:0] RST_BIT_PERIOD = 16'd80;
  localparam logic [CNT_W-1:0] RST_LED_GAP    = 16'd64;
  localparam logic [LEN_W-1:0] RST_STRIP_LEN  = 8'd255;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] one_high;
    logic [CNT_W-1:0] zero_high;
    logic [CNT_W-1:0] bit_period;
    logic [CNT_W-1:0] led_gap;
    logic [LEN_W-1:0] strip_length;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

// File: design/addressable_led_single_pixel_driver.sv
// Single-wire addressable LED strip driver that lights one chosen LED per frame.
// Depends on led_drv_pkg, led_drv_cfg, led_drv_core and led_drv_out.
//
// Every request on the slave stream yields exactly one result on the master stream.
// A request with tuser set starts a frame: it latches the color and the 1-based LED
// position and takes no wire time; it is ignored while a frame is running. A request
// with tuser clear is one tick of the wire clock and returns the wire level for that
// tick, whether a frame was running, and on tlast the end of the frame. Position zero
// or beyond the strip length (a length of zero is one) sends an all-off frame.
// One request is taken every cycle as long as the result register is empty or being
// drained the same cycle. When the receiver stalls, the held result stays put and
// s_tready drops until it is taken; no result is lost or repeated. Timing registers
// are written through cfg_we/cfg_index/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. Reset loads the default
// timing, ends any frame and empties the result register.
module addressable_led_single_pixel_driver #(
  parameter int BITS_PER_LED   = led_drv_pkg::DEF_BITS_PER_LED,
  parameter int MAX_STRIP_LEDS = led_drv_pkg::DEF_MAX_STRIP_LEDS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // red [7:0], green [15:8], blue [23:16], led_position [31:24]
  input  logic [led_drv_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type [0]
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // line_level [0], busy_res [1], zero [7:2]
  output logic [led_drv_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [led_drv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [led_drv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import led_drv_pkg::*;

  cfg_t cfg;
  res_t res;
  logic accept;

  assign accept = s_tvalid && s_tready;

  led_drv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  led_drv_core #(
    .BITS_PER_LED   (BITS_PER_LED),
    .MAX_STRIP_LEDS (MAX_STRIP_LEDS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .req_type     (s_tuser[0]),
    .red          (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .led_position (s_tdata[31:24]),
    .res          (res)
  );

  led_drv_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/led_drv_cfg.sv
// Configuration register bank of the LED strip driver.
// Depends on led_drv_pkg for the register indexes, reset values and cfg_t.
module led_drv_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [led_drv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [led_drv_pkg::CFG_DATA_W-1:0]    cfg_data,
  output led_drv_pkg::cfg_t                     cfg
);
  import led_drv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high     <= RST_ONE_HIGH;
      cfg.zero_high    <= RST_ZERO_HIGH;
      cfg.bit_period   <= RST_BIT_PERIOD;
      cfg.led_gap      <= RST_LED_GAP;
      cfg.strip_length <= RST_STRIP_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_HIGH:   cfg.one_high     <= cfg_data;
        CFG_ZERO_HIGH:  cfg.zero_high    <= cfg_data;
        CFG_BIT_PERIOD: cfg.bit_period   <= cfg_data;
        CFG_LED_GAP:    cfg.led_gap      <= cfg_data;
        CFG_STRIP_LEN:  cfg.strip_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/led_drv_core.sv
// Frame sequencer of the LED strip driver: state registers and the per-request update.
// Depends on led_drv_pkg for cfg_t, res_t and the request kinds.
module led_drv_core #(
  parameter int BITS_PER_LED   = led_drv_pkg::DEF_BITS_PER_LED,
  parameter int MAX_STRIP_LEDS = led_drv_pkg::DEF_MAX_STRIP_LEDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  led_drv_pkg::cfg_t             cfg,
  input  logic                          accept,
  input  logic                          req_type,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic [led_drv_pkg::LEN_W-1:0] led_position,
  output led_drv_pkg::res_t             res
);
  import led_drv_pkg::*;

  localparam int BI_W = $clog2(BITS_PER_LED);

  logic                  sending, sending_next;
  logic                  in_gap, in_gap_next;
  logic [CNT_W-1:0]      cycle_count, cycle_count_next;
  logic [BI_W-1:0]       bit_index, bit_index_next;
  logic [LEN_W-1:0]      led_index, led_index_next;
  logic [LEN_W-1:0]      target_led;
  logic [COLOR_BITS-1:0] grb_word;

  logic [CNT_W:0]        cnt_inc;
  logic [CNT_W-1:0]      period;
  logic [BI_W:0]         bit_inc;
  logic [LEN_W-1:0]      num_leds;
  logic [4:0]            color_pos;
  logic                  cur_bit;
  logic [CNT_W-1:0]      high_len;
  logic                  level;
  logic                  led_last;
  logic                  done;

  always_comb begin
    num_leds = (cfg.strip_length == '0) ? LEN_W'(1) : cfg.strip_length;
    if (num_leds > LEN_W'(MAX_STRIP_LEDS)) begin
      num_leds = LEN_W'(MAX_STRIP_LEDS);
    end
    led_last = (led_index >= num_leds);
    period   = (cfg.bit_period == '0) ? CNT_W'(1) : cfg.bit_period;
    cnt_inc  = {1'b0, cycle_count} + (CNT_W+1)'(1);
    bit_inc  = {1'b0, bit_index} + (BI_W+1)'(1);
  end

  always_comb begin
    color_pos = 5'(COLOR_BITS - 1) - 5'(bit_index);
    cur_bit   = (led_index == target_led) && ((BI_W+1)'(bit_index) < (BI_W+1)'(COLOR_BITS))
                && grb_word[color_pos];
    high_len  = cur_bit ? cfg.one_high : cfg.zero_high;
    level     = sending && !in_gap && (cycle_count < high_len);
  end

  always_comb begin
    sending_next     = sending;
    in_gap_next      = in_gap;
    cycle_count_next = cycle_count;
    bit_index_next   = bit_index;
    led_index_next   = led_index;
    done             = 1'b0;
    res.line_level   = level;
    if (req_type == REQ_START) begin
      if (!sending) begin
        sending_next     = 1'b1;
        in_gap_next      = 1'b0;
        cycle_count_next = '0;
        bit_index_next   = '0;
        led_index_next   = LEN_W'(1);
      end
      res.busy_res = 1'b1;
    end else begin
      res.busy_res = sending;
      if (sending) begin
        cycle_count_next = cnt_inc[CNT_W-1:0];
        if (in_gap) begin
          if (cnt_inc >= {1'b0, cfg.led_gap}) begin
            cycle_count_next = '0;
            in_gap_next      = 1'b0;
            if (led_last) begin
              sending_next = 1'b0;
              done         = 1'b1;
            end else begin
              led_index_next = led_index + LEN_W'(1);
            end
          end
        end else if (cnt_inc >= {1'b0, period}) begin
          cycle_count_next = '0;
          bit_index_next   = bit_inc[BI_W-1:0];
          if (bit_inc >= (BI_W+1)'(BITS_PER_LED)) begin
            bit_index_next = '0;
            if (cfg.led_gap != '0) begin
              in_gap_next = 1'b1;
            end else if (led_last) begin
              sending_next = 1'b0;
              done         = 1'b1;
            end else begin
              led_index_next = led_index + LEN_W'(1);
            end
          end
        end
      end
    end
    res.frame_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending     <= 1'b0;
      in_gap      <= 1'b0;
      cycle_count <= '0;
      bit_index   <= '0;
      led_index   <= '0;
    end else if (accept) begin
      sending     <= sending_next;
      in_gap      <= in_gap_next;
      cycle_count <= cycle_count_next;
      bit_index   <= bit_index_next;
      led_index   <= led_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grb_word   <= '0;
      target_led <= '0;
    end else if (accept && req_type == REQ_START && !sending) begin
      grb_word   <= {green, red, blue};
      target_led <= led_position;
    end
  end

  a_gap_only_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_gap |-> sending) else $error("gap flag set outside a frame");

  a_led_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    sending |-> led_index != '0) else $error("LED index zero during a frame");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> !sending) else $error("frame still running after done");

endmodule

// File: design/led_drv_out.sv
// Result register of the LED strip driver; packs the result onto the master stream.
// Depends on led_drv_pkg for res_t and the output data width.
module led_drv_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  led_drv_pkg::res_t                   res,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [led_drv_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                                m_tlast
);
  import led_drv_pkg::*;

  res_t held;

  assign in_ready = !m_tvalid || m_tready;
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, held.busy_res, held.line_level};
  assign m_tlast  = held.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= res;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !in_ready) else $error("request taken over a stalled result");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(held)) else $error("stalled result changed");

endmodule

// File: tb/led_wire_checker.sv
// Checker for the single-pixel LED strip driver: predicts the wire level, busy and
// end-of-frame flags of every accepted request and compares them with the results.
// Depends on led_drv_pkg; instantiated beside the driver by the testbench top.
module led_wire_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // red [7:0], green [15:8], blue [23:16], led_position [31:24]
  input  logic [led_drv_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type [0]
  input  logic [0:0]                         s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // line_level [0], busy_res [1], zero [7:2]
  input  logic [led_drv_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [led_drv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [led_drv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 errors,
  output int                                 pending,
  output int                                 frames_started,
  output int                                 frames_seen,
  output logic                               frame_running
);
  timeunit 1ns;
  timeprecision 1ps;
  import led_drv_pkg::*;

  cfg_t        timing;
  logic        active;
  logic        gap_phase;
  int unsigned tick_cnt;
  int unsigned bit_pos;
  int unsigned led_pos;
  int unsigned chosen_led;
  logic [23:0] grb;
  res_t        wire_results_q[$];
  int          fail_count;
  int          results_seen;
  int          starts_taken;
  int          done_count;

  function automatic int unsigned leds_in_frame();
    int unsigned n;
    n = 32'(timing.strip_length);
    if (n == 0) n = 1;
    if (n > DEF_MAX_STRIP_LEDS) n = DEF_MAX_STRIP_LEDS;
    return n;
  endfunction

  function automatic logic wire_level();
    int unsigned high;
    if (!active || gap_phase) return 1'b0;
    if (led_pos == chosen_led && bit_pos < COLOR_BITS && grb[COLOR_BITS - 1 - bit_pos]) begin
      high = 32'(timing.one_high);
    end else begin
      high = 32'(timing.zero_high);
    end
    return (tick_cnt < high);
  endfunction

  function automatic logic close_led();
    if (led_pos >= leds_in_frame()) begin
      active = 1'b0;
      return 1'b1;
    end
    led_pos = (led_pos + 1) & 8'hFF;
    return 1'b0;
  endfunction

  function automatic res_t predict_wire(logic kind, logic [IN_DATA_W-1:0] pix);
    res_t        r;
    int unsigned period;
    r.line_level = wire_level();
    r.frame_done = 1'b0;
    if (kind == REQ_START) begin
      if (!active) begin
        grb = {pix[15:8], pix[7:0], pix[23:16]};
        chosen_led = 32'(pix[31:24]);
        active = 1'b1;
        gap_phase = 1'b0;
        tick_cnt = 0;
        bit_pos = 0;
        led_pos = 1;
        starts_taken++;
      end
      r.busy_res = active;
    end else begin
      r.busy_res = active;
      if (active) begin
        tick_cnt++;
        if (gap_phase) begin
          if (tick_cnt >= timing.led_gap) begin
            tick_cnt = 0;
            gap_phase = 1'b0;
            r.frame_done = close_led();
          end
        end else begin
          period = (timing.bit_period == 0) ? 1 : 32'(timing.bit_period);
          if (tick_cnt >= period) begin
            tick_cnt = 0;
            bit_pos++;
            if (bit_pos >= DEF_BITS_PER_LED) begin
              bit_pos = 0;
              if (timing.led_gap > 0) gap_phase = 1'b1;
              else r.frame_done = close_led();
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      timing.one_high = RST_ONE_HIGH;
      timing.zero_high = RST_ZERO_HIGH;
      timing.bit_period = RST_BIT_PERIOD;
      timing.led_gap = RST_LED_GAP;
      timing.strip_length = RST_STRIP_LEN;
      active = 1'b0;
      gap_phase = 1'b0;
      tick_cnt = 0;
      bit_pos = 0;
      led_pos = 0;
      chosen_led = 0;
      grb = '0;
      wire_results_q.delete();
      fail_count = 0;
      results_seen = 0;
      starts_taken = 0;
      done_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ONE_HIGH:   timing.one_high = cfg_data;
          CFG_ZERO_HIGH:  timing.zero_high = cfg_data;
          CFG_BIT_PERIOD: timing.bit_period = cfg_data;
          CFG_LED_GAP:    timing.led_gap = cfg_data;
          CFG_STRIP_LEN:  timing.strip_length = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (wire_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d arrived with no request outstanding: data %0h, tlast %0b",
                     results_seen, m_tdata, m_tlast);
          end
        end else begin
          want = wire_results_q.pop_front();
          check_field("line_level", 8'(want.line_level), 8'(m_tdata[0]));
          check_field("busy_res", 8'(want.busy_res), 8'(m_tdata[1]));
          check_field("frame_done", 8'(want.frame_done), 8'(m_tlast));
          check_field("padding", 8'h00, 8'(m_tdata[7:2]));
          if (want.frame_done) done_count++;
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) wire_results_q.push_back(predict_wire(s_tuser[0], s_tdata));
    end
    errors <= fail_count;
    pending <= wire_results_q.size();
    frames_started <= starts_taken;
    frames_seen <= done_count;
    frame_running <= active;
  end

endmodule

// File: tb/tb_addressable_led_single_pixel_driver.sv
// Testbench top for the single-pixel LED strip driver: resets the block, writes its
// timing registers and drives tick and start requests with random stalls on both sides.
// Depends on led_drv_pkg, the driver RTL and led_wire_checker.
module tb_addressable_led_single_pixel_driver;
  timeunit 1ns;
  timeprecision 1ps;
  import led_drv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int LONG_HOLD      = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   errors;
  int   pending;
  int   frames_started;
  int   frames_seen;
  logic frame_running;

  int items_sent = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  bit idle_on = 1'b1;

  always #6 clk = ~clk;

  addressable_led_single_pixel_driver u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_wire_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .frames_started (frames_started),
    .frames_seen    (frames_seen),
    .frame_running  (frame_running)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    m_tready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pixel(logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b, logic [7:0] pos);
    return {pos, b, g, r};
  endfunction

  task automatic send_req(input logic kind, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    if (!(kind == REQ_START && frame_running)) items_sent++;
  endtask

  task automatic sender_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    sender_idle();
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic finish_frame();
    sender_idle();
    while (frame_running) send_req(REQ_TICK, $urandom);
    settle();
  endtask

  task automatic configure(input int one_hi, input int zero_hi, input int period,
                           input int gap, input int len);
    logic [CFG_IDX_W-1:0]  regs[5];
    logic [CFG_DATA_W-1:0] vals[5];
    regs = '{CFG_ONE_HIGH, CFG_ZERO_HIGH, CFG_BIT_PERIOD, CFG_LED_GAP, CFG_STRIP_LEN};
    vals = '{one_hi[15:0], zero_hi[15:0], period[15:0], gap[15:0], len[15:0]};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes += 5;
  endtask

  initial begin : stimulus
    int          random_goal;
    int          phase;
    int          len;
    int          n;
    logic [7:0]  pos;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_TICK;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ONE_HIGH;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ticks with no frame running under the reset timing.
    send_req(REQ_TICK, 32'hFFFF_FFFF);
    send_req(REQ_TICK, 32'h0000_0000);
    settle();

    configure(2, 1, 2, 1, 2);
    send_req(REQ_START, pixel(8'hFF, 8'hFF, 8'hFF, 8'd1));
    finish_frame();
    send_req(REQ_START, pixel(8'h00, 8'h00, 8'h00, 8'd2));
    finish_frame();
    send_req(REQ_START, pixel(8'h3C, 8'hC3, 8'h81, 8'd2));
    finish_frame();
    send_req(REQ_START, pixel(8'hFF, 8'hFF, 8'hFF, 8'd0));
    finish_frame();
    send_req(REQ_START, pixel(8'hAA, 8'h55, 8'hF0, 8'd3));
    repeat (3) send_req(REQ_TICK, $urandom);
    // A start while the frame is running must be ignored.
    send_req(REQ_START, pixel(8'hFF, 8'hFF, 8'hFF, 8'd1));
    finish_frame();
    send_req(REQ_START, pixel(8'hFF, 8'hFF, 8'hFF, 8'd255));
    finish_frame();

    configure(1, 0, 1, 0, 0);
    send_req(REQ_START, pixel(8'hA5, 8'h5A, 8'hC3, 8'd1));
    finish_frame();
    configure(7, 2, 0, 0, 1);
    send_req(REQ_START, pixel(8'h0F, 8'hF0, 8'h99, 8'd1));
    finish_frame();

    idle_on = 1'b0;
    configure(1, 1, 1, 0, 10);
    send_req(REQ_START, pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'd10));
    finish_frame();
    configure(1, 1, 2, 150, 1);
    send_req(REQ_START, pixel(8'h80, 8'h01, 8'h7E, 8'd1));
    finish_frame();
    idle_on = 1'b1;

    // Slowest timing, then a change of period and strip length while the frame runs.
    configure(65535, 1, 65535, 1, 2);
    send_req(REQ_START, pixel(8'h80, 8'h01, 8'hFF, 8'd1));
    repeat (100) send_req(REQ_TICK, $urandom);
    settle();
    configure(65535, 1, 3, 1, 1);
    finish_frame();

    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      configure($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                $urandom_range(0, 4), len);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        idle_on = 1'b0;
        hold_request = LONG_HOLD;
      end
      n = $urandom_range(120, 300);
      repeat (n) begin
        if ($urandom_range(0, 29) == 0) begin
          pos = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, len + 1));
          send_req(REQ_START, pixel(8'($urandom), 8'($urandom), 8'($urandom), pos));
        end else begin
          send_req(REQ_TICK, $urandom);
        end
      end
      finish_frame();
      phase++;
    end

    idle_on = 1'b1;
    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d requests over %0d random timing sets and %0d register writes",
             items_sent, phase, reg_writes);
    $display("frames started %0d, frames completed %0d, failures %0d",
             frames_started, frames_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
